FILE: rtl/core/dsqrt_pkg.sv
// Package for the binary64 integer square root unit.
// Holds the binary64 field constants, root iteration sizes and the FSM state type.
// No dependencies.
`default_nettype none

package dsqrt_pkg;

  // binary64 field layout
  localparam int unsigned FRAC_BITS = 52;
  localparam logic [63:0] FRAC_MASK = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] HIDDEN_BIT = 64'h0010_0000_0000_0000;
  localparam logic [10:0] EXP_MASK = 11'h7ff;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  // biased exponent at which the integer no longer fits in 64 bits
  localparam logic [10:0] EXP_SAT = 11'd1087;
  // biased exponent at which the mantissa is already an integer
  localparam logic [10:0] EXP_INT = 11'd1075;

  // restoring square root: one result bit per step
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned CNT_W = $clog2(ROOT_STEPS);
  localparam logic [63:0] ROOT_BIT_INIT = 64'h4000_0000_0000_0000;

  // encoding of floor(sqrt(2^64-1)) = 2^32-1
  localparam logic [63:0] SAT_ROOT_BITS = 64'h41ef_ffff_ffe0_0000;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ITER   = 3'b010,
    S_ENCODE = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/double_integer_square_root_unit.sv
// Integer square root of a binary64 operand, returned as a binary64 value.
// Top level; depends on dsqrt_pkg.
`default_nettype none

// One transaction at a time. The operand is decoded to a 64-bit unsigned
// integer (sign ignored, magnitude truncated, saturated to all ones with
// out_too_large set when it needs more than 64 bits) in the cycle it is
// accepted. A single 64-bit add/compare/subtract unit then produces one root
// bit per cycle, and an encode state then writes the root to the output
// register, once it is free, as an exact binary64 value (0 encodes as
// all-zero bits). A new operand is accepted only after the previous result
// has been written to the output register. in_stall is high while a
// transaction is being computed; a finished result waiting in the output
// register does not block the next operand until encoding needs it.
module double_integer_square_root_unit
  import dsqrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_float_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_root_bits,
  output logic             out_too_large
);

  state_t             state_r, state_nxt;
  logic [63:0]        n_r, n_nxt;
  logic [63:0]        root_r, root_nxt;
  logic [63:0]        bit_r, bit_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   msb_r, msb_nxt;
  logic               hit_r, hit_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_root_r, out_root_nxt;
  logic               out_sat_r, out_sat_nxt;

  logic               in_fire;
  logic               out_free;
  logic [10:0]        exp_w;
  logic [52:0]        mant_w;
  logic [10:0]        lsh_w;
  logic [10:0]        rsh_w;
  logic [63:0]        dec_mag;
  logic               dec_sat;
  logic [63:0]        trial;
  logic               take;
  logic [5:0]         enc_sh;
  logic [63:0]        enc_frac;
  logic [10:0]        enc_exp;
  logic [63:0]        enc_bits;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // decode: truncate the magnitude to an unsigned integer
  assign exp_w  = in_float_bits[62:52] & EXP_MASK;
  assign mant_w = 53'((in_float_bits & FRAC_MASK) | HIDDEN_BIT);
  assign lsh_w  = exp_w - EXP_INT;
  assign rsh_w  = EXP_INT - exp_w;

  always_comb begin
    dec_sat = 1'b0;
    priority if (exp_w < EXP_BIAS) begin
      dec_mag = '0;
    end else if (exp_w >= EXP_SAT) begin
      dec_mag = '1;
      dec_sat = 1'b1;
    end else if (exp_w >= EXP_INT) begin
      dec_mag = {11'b0, mant_w} << lsh_w[3:0];
    end else begin
      dec_mag = {11'b0, mant_w} >> rsh_w[5:0];
    end
  end

  // shared restoring step
  assign trial = root_r + bit_r;
  assign take  = (n_r >= trial);

  // encode: msb of the root was captured on its first set bit
  assign enc_sh   = 6'(FRAC_BITS) - {1'b0, msb_r};
  assign enc_frac = ({32'b0, root_r[31:0]} << enc_sh) & FRAC_MASK;
  assign enc_exp  = EXP_BIAS + {6'b0, msb_r};
  assign enc_bits = hit_r ? {1'b0, enc_exp, enc_frac[51:0]} : '0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    msb_nxt       = msb_r;
    hit_nxt       = hit_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_root_nxt  = out_root_r;
    out_sat_nxt   = out_sat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_nxt     = dec_mag;
          sat_nxt   = dec_sat;
          root_nxt  = '0;
          bit_nxt   = ROOT_BIT_INIT;
          cnt_nxt   = '0;
          msb_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        if (take) begin
          n_nxt    = n_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
          if (!hit_r) begin
            hit_nxt = 1'b1;
            msb_nxt = CNT_W'(ROOT_STEPS - 1) - cnt_r;
          end
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_ENCODE;
        end
      end
      S_ENCODE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = enc_bits;
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    msb_r      <= msb_nxt;
    hit_r      <= hit_nxt;
    sat_r      <= sat_nxt;
    out_root_r <= out_root_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_root_bits = out_root_r;
  assign out_too_large = out_sat_r;

  // checks
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ENCODE |-> root_r[63:32] == 32'b0)
    else $error("root exceeds 32 bits at encode");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ENCODE |-> hit_r == (root_r != 64'b0))
    else $error("first-bit flag disagrees with root");

  a_msb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENCODE && hit_r) |-> (root_r[31:0] >> msb_r) == 32'd1)
    else $error("captured msb is wrong");

  a_sat_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> out_root_r == SAT_ROOT_BITS)
    else $error("saturated operand gave wrong root");

endmodule

`default_nettype wire
